// ===== rtl/ray_sphere_intersection_macros.svh =====
// -----------------------------------------------------------------------------
// Ray-sphere intersection: assertion macros
// Property shorthands for the port checker.
// -----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECTION_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_MACROS_SVH

// same-cycle implication, checked outside reset
`define RSI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
// -----------------------------------------------------------------------------
// Ray-sphere intersection package
// Word widths and derived datapath widths shared by the pipeline modules.
// -----------------------------------------------------------------------------
package rsi_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int OC_W   = WORD_BITS + 1;        // origin - center
    localparam int SQ_W   = 2 * WORD_BITS;        // a = |dir|^2, unsigned
    localparam int PD_W   = OC_W + WORD_BITS;     // oc * dir product
    localparam int OO_W   = 2 * OC_W;             // oc * oc product
    localparam int RR_W   = 2 * (WORD_BITS - 1);  // radius^2
    localparam int HB_W   = 2 * WORD_BITS + 2;    // half_b, signed
    localparam int C_W    = 2 * WORD_BITS + 3;    // c, signed
    localparam int HBM_W  = HB_W - 1;             // |half_b|
    localparam int CM_W   = C_W - 1;              // |c|
    localparam int DLT_W  = 2 * HB_W;             // delta, signed
    localparam int RAD_W  = DLT_W - 2;            // nonnegative delta
    localparam int ROOT_W = RAD_W / 2;            // floor sqrt(delta)
    localparam int REM_W  = ROOT_W + 2;           // sqrt remainder
    localparam int SUM_W  = HB_W + 1;             // half_b +/- root
    localparam int NUM_W  = HB_W + FRAC_BITS;     // scaled numerator magnitude
    localparam int T_W    = NUM_W + 1;            // signed quotient

    typedef struct packed {
        logic signed [WORD_BITS-1:0] t_min;
        logic signed [WORD_BITS-1:0] t_max;
    } win_t;

endpackage

// ===== rtl/rsi_div_pipe.sv =====
// -----------------------------------------------------------------------------
// Ray-sphere intersection: pipelined divider
// Unsigned restoring division, one quotient bit per register stage.
// -----------------------------------------------------------------------------
module rsi_div_pipe (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [rsi_pkg::NUM_W-1:0]     num,
    input  logic [rsi_pkg::SQ_W-1:0]      den,
    output logic [rsi_pkg::NUM_W-1:0]     quo
);

    localparam int NW = rsi_pkg::NUM_W;
    localparam int DW = rsi_pkg::SQ_W;

    // numerator shifts out at the top while quotient bits shift in below
    logic [NW-1:0] nq_reg  [0:NW-1];
    logic [DW-1:0] rem_reg [0:NW-1];
    logic [DW-1:0] den_reg [0:NW-1];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_step
            logic [NW-1:0] nq_in;
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   r_sh;
            logic          take;

            if (k == 0) begin : g_first
                assign nq_in  = num;
                assign rem_in = '0;
                assign den_in = den;
            end else begin : g_rest
                assign nq_in  = nq_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign r_sh = {rem_in, nq_in[NW-1]};
            assign take = r_sh >= {1'b0, den_in};

            always_ff @(posedge aclk) begin
                if (en) begin
                    nq_reg[k]  <= {nq_in[NW-2:0], take};
                    rem_reg[k] <= take ? DW'(r_sh - {1'b0, den_in}) : r_sh[DW-1:0];
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[NW-1];

endmodule

// ===== rtl/ray_sphere_intersection.sv =====
// -----------------------------------------------------------------------------
// Ray-sphere intersection
// Fixed-point Q16.16 ray-sphere hit test, fully pipelined.
// -----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one test per item: ray origin and direction, sphere
//   center and radius, and an inclusive hit window [t_min, t_max].
//   m_ channel returns one item per test: hit flag, hit distance t_hit
//   (zero on a miss) and far_root when the far intersection was taken.
//   The pipe has 157 register stages: 7 setup stages for the dot products and
//   the discriminant, 65 square-root stages (one root bit each), 1 numerator
//   stage, 82 divider stages (one quotient bit each, near and far roots
//   divided side by side) and 2 select/output stages. Throughput is one
//   item per cycle while m_ready is high.
//   The whole pipe advances on one enable; when the receiver holds m_ready
//   low with a result waiting, every stage holds, bubbles included, and
//   s_ready drops; nothing is lost or repeated. While the output register
//   is empty the pipe keeps moving.
//   Reset (aresetn low, synchronous) clears all valid bits; data registers
//   are not reset.
// -----------------------------------------------------------------------------
module ray_sphere_intersection (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_origin_x,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_origin_y,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_origin_z,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_dir_x,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_dir_y,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_dir_z,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_center_x,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_center_y,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_center_z,
    input  logic        [rsi_pkg::WORD_BITS-2:0]   s_radius,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_t_min,
    input  logic signed [rsi_pkg::WORD_BITS-1:0]   s_t_max,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_hit,
    output logic signed [rsi_pkg::WORD_BITS-1:0]   m_t_hit,
    output logic                                   m_far_root
);

    localparam int W      = rsi_pkg::WORD_BITS;
    localparam int F      = rsi_pkg::FRAC_BITS;
    localparam int OC_W   = rsi_pkg::OC_W;
    localparam int SQ_W   = rsi_pkg::SQ_W;
    localparam int PD_W   = rsi_pkg::PD_W;
    localparam int OO_W   = rsi_pkg::OO_W;
    localparam int RR_W   = rsi_pkg::RR_W;
    localparam int HB_W   = rsi_pkg::HB_W;
    localparam int C_W    = rsi_pkg::C_W;
    localparam int HBM_W  = rsi_pkg::HBM_W;
    localparam int CM_W   = rsi_pkg::CM_W;
    localparam int DLT_W  = rsi_pkg::DLT_W;
    localparam int RAD_W  = rsi_pkg::RAD_W;
    localparam int ROOT_W = rsi_pkg::ROOT_W;
    localparam int REM_W  = rsi_pkg::REM_W;
    localparam int SUM_W  = rsi_pkg::SUM_W;
    localparam int NUM_W  = rsi_pkg::NUM_W;
    localparam int T_W    = rsi_pkg::T_W;

    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: oc = origin - center ----------------
    logic                   v1_reg;
    logic signed [OC_W-1:0] ocx_reg, ocy_reg, ocz_reg;
    logic signed [W-1:0]    dx_reg, dy_reg, dz_reg;
    logic [W-2:0]           rad1_reg;
    rsi_pkg::win_t          win1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ocx_reg        <= OC_W'(s_origin_x) - OC_W'(s_center_x);
            ocy_reg        <= OC_W'(s_origin_y) - OC_W'(s_center_y);
            ocz_reg        <= OC_W'(s_origin_z) - OC_W'(s_center_z);
            dx_reg         <= s_dir_x;
            dy_reg         <= s_dir_y;
            dz_reg         <= s_dir_z;
            rad1_reg       <= s_radius;
            win1_reg.t_min <= s_t_min;
            win1_reg.t_max <= s_t_max;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [SQ_W-1:0] dxx_next, dyy_next, dzz_next;
    logic signed [PD_W-1:0] hx_next, hy_next, hz_next;
    logic signed [OO_W-1:0] oxx_next, oyy_next, ozz_next;
    logic [RR_W-1:0]        rr_next;

    assign dxx_next = dx_reg * dx_reg;
    assign dyy_next = dy_reg * dy_reg;
    assign dzz_next = dz_reg * dz_reg;
    assign hx_next  = ocx_reg * dx_reg;
    assign hy_next  = ocy_reg * dy_reg;
    assign hz_next  = ocz_reg * dz_reg;
    assign oxx_next = ocx_reg * ocx_reg;
    assign oyy_next = ocy_reg * ocy_reg;
    assign ozz_next = ocz_reg * ocz_reg;
    assign rr_next  = rad1_reg * rad1_reg;

    logic                   v2_reg;
    logic [SQ_W-1:0]        dxx_reg, dyy_reg, dzz_reg;
    logic signed [PD_W-1:0] hx_reg, hy_reg, hz_reg;
    logic signed [OO_W-1:0] oxx_reg, oyy_reg, ozz_reg;
    logic [RR_W-1:0]        rr_reg;
    rsi_pkg::win_t          win2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dxx_reg  <= dxx_next;
            dyy_reg  <= dyy_next;
            dzz_reg  <= dzz_next;
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
            hz_reg   <= hz_next;
            oxx_reg  <= oxx_next;
            oyy_reg  <= oyy_next;
            ozz_reg  <= ozz_next;
            rr_reg   <= rr_next;
            win2_reg <= win1_reg;
        end
    end

    // ---------------- stage 3: a, half_b, c ----------------
    logic [SQ_W-1:0]        a_next;
    logic signed [HB_W-1:0] hb_next;
    logic signed [C_W-1:0]  c_next;

    assign a_next  = dxx_reg + dyy_reg + dzz_reg;
    assign hb_next = hx_reg + hy_reg + hz_reg;
    assign c_next  = oxx_reg + oyy_reg + ozz_reg - $signed({1'b0, rr_reg});

    logic                   v3_reg;
    logic [SQ_W-1:0]        a3_reg;
    logic signed [HB_W-1:0] hb3_reg;
    logic signed [C_W-1:0]  c3_reg;
    rsi_pkg::win_t          win3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg   <= a_next;
            hb3_reg  <= hb_next;
            c3_reg   <= c_next;
            win3_reg <= win2_reg;
        end
    end

    // ---------------- stage 4: magnitudes for the wide products ----------------
    logic                   v4_reg;
    logic [SQ_W-1:0]        a4_reg;
    logic signed [HB_W-1:0] hb4_reg;
    logic [HBM_W-1:0]       hbm4_reg;
    logic [CM_W-1:0]        cm4_reg;
    logic                   cneg4_reg;
    rsi_pkg::win_t          win4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a4_reg    <= a3_reg;
            hb4_reg   <= hb3_reg;
            hbm4_reg  <= hb3_reg[HB_W-1] ? HBM_W'(-hb3_reg) : hb3_reg[HBM_W-1:0];
            cm4_reg   <= c3_reg[C_W-1] ? CM_W'(-c3_reg) : c3_reg[CM_W-1:0];
            cneg4_reg <= c3_reg[C_W-1];
            win4_reg  <= win3_reg;
        end
    end

    // ---------------- stage 5: limb partial products ----------------
    // half_b^2 from a 33/32-bit split, a*|c| from 32/32 x 34/32
    logic [2*(HBM_W-W)-1:0]      p_hh_next;
    logic [HBM_W-1:0]            p_hl_next;
    logic [2*W-1:0]              p_ll_next;
    logic [(SQ_W-W)+(CM_W-W)-1:0] p_ahch_next;
    logic [2*W-1:0]              p_ahcl_next;
    logic [W+(CM_W-W)-1:0]       p_alch_next;
    logic [2*W-1:0]              p_alcl_next;

    assign p_hh_next   = hbm4_reg[HBM_W-1:W] * hbm4_reg[HBM_W-1:W];
    assign p_hl_next   = hbm4_reg[HBM_W-1:W] * hbm4_reg[W-1:0];
    assign p_ll_next   = hbm4_reg[W-1:0] * hbm4_reg[W-1:0];
    assign p_ahch_next = a4_reg[SQ_W-1:W] * cm4_reg[CM_W-1:W];
    assign p_ahcl_next = a4_reg[SQ_W-1:W] * cm4_reg[W-1:0];
    assign p_alch_next = a4_reg[W-1:0] * cm4_reg[CM_W-1:W];
    assign p_alcl_next = a4_reg[W-1:0] * cm4_reg[W-1:0];

    logic                         v5_reg;
    logic [SQ_W-1:0]              a5_reg;
    logic signed [HB_W-1:0]       hb5_reg;
    logic                         cneg5_reg;
    rsi_pkg::win_t                win5_reg;
    logic [2*(HBM_W-W)-1:0]       p_hh_reg;
    logic [HBM_W-1:0]             p_hl_reg;
    logic [2*W-1:0]               p_ll_reg;
    logic [(SQ_W-W)+(CM_W-W)-1:0] p_ahch_reg;
    logic [2*W-1:0]               p_ahcl_reg;
    logic [W+(CM_W-W)-1:0]        p_alch_reg;
    logic [2*W-1:0]               p_alcl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a5_reg     <= a4_reg;
            hb5_reg    <= hb4_reg;
            cneg5_reg  <= cneg4_reg;
            win5_reg   <= win4_reg;
            p_hh_reg   <= p_hh_next;
            p_hl_reg   <= p_hl_next;
            p_ll_reg   <= p_ll_next;
            p_ahch_reg <= p_ahch_next;
            p_ahcl_reg <= p_ahcl_next;
            p_alch_reg <= p_alch_next;
            p_alcl_reg <= p_alcl_next;
        end
    end

    // ---------------- stage 6: sum partials ----------------
    logic [RAD_W-1:0] hb2_next, ac_next;

    assign hb2_next = (RAD_W'(p_hh_reg) << (2 * W)) + (RAD_W'(p_hl_reg) << (W + 1))
                    + RAD_W'(p_ll_reg);
    assign ac_next  = (RAD_W'(p_ahch_reg) << (2 * W)) + (RAD_W'(p_ahcl_reg) << W)
                    + (RAD_W'(p_alch_reg) << W) + RAD_W'(p_alcl_reg);

    logic                   v6_reg;
    logic [SQ_W-1:0]        a6_reg;
    logic signed [HB_W-1:0] hb6_reg;
    logic                   cneg6_reg;
    rsi_pkg::win_t          win6_reg;
    logic [RAD_W-1:0]       hb2_reg, ac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a6_reg    <= a5_reg;
            hb6_reg   <= hb5_reg;
            cneg6_reg <= cneg5_reg;
            win6_reg  <= win5_reg;
            hb2_reg   <= hb2_next;
            ac_reg    <= ac_next;
        end
    end

    // ---------------- stage 7: delta, hit precondition ----------------
    logic signed [DLT_W-1:0] dlt_next;
    logic                    ok_next;

    assign dlt_next = cneg6_reg ? (DLT_W'(hb2_reg) + DLT_W'(ac_reg))
                                : (DLT_W'(hb2_reg) - DLT_W'(ac_reg));
    assign ok_next  = (a6_reg != '0) && !dlt_next[DLT_W-1];

    // square-root pipe, index 0 is the stage-7 register
    logic                   sq_v_reg    [0:ROOT_W];
    logic                   sq_ok_reg   [0:ROOT_W];
    logic [RAD_W-1:0]       sq_rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]       sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]      sq_root_reg [0:ROOT_W];
    logic signed [HB_W-1:0] sq_hb_reg   [0:ROOT_W];
    logic [SQ_W-1:0]        sq_a_reg    [0:ROOT_W];
    rsi_pkg::win_t          sq_win_reg  [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_ok_reg[0]   <= ok_next;
            sq_rad_reg[0]  <= ok_next ? dlt_next[RAD_W-1:0] : '0;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_hb_reg[0]   <= hb6_reg;
            sq_a_reg[0]    <= a6_reg;
            sq_win_reg[0]  <= win6_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_sqrt
            logic [REM_W+1:0] rem_sh;
            logic [REM_W+1:0] trial;
            logic             take;

            // bring in the next two radicand bits, try root*4+1
            assign rem_sh = {sq_rem_reg[k], sq_rad_reg[k][RAD_W-1 -: 2]};
            assign trial  = (REM_W + 2)'({sq_root_reg[k], 2'b01});
            assign take   = rem_sh >= trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq_v_reg[k+1] <= 1'b0;
                end else if (en) begin
                    sq_v_reg[k+1] <= sq_v_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_ok_reg[k+1]   <= sq_ok_reg[k];
                    sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
                    sq_rem_reg[k+1]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                    sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], take};
                    sq_hb_reg[k+1]   <= sq_hb_reg[k];
                    sq_a_reg[k+1]    <= sq_a_reg[k];
                    sq_win_reg[k+1]  <= sq_win_reg[k];
                end
            end
        end
    endgenerate

    // ---------------- numerator stage ----------------
    // near = -(half_b + s), far = s - half_b; split into sign and magnitude
    logic signed [SUM_W-1:0] sum_n, dif_f;
    logic [HB_W-1:0]         mag_n, mag_f;

    assign sum_n = sq_hb_reg[ROOT_W] + $signed({2'b00, sq_root_reg[ROOT_W]});
    assign dif_f = $signed({2'b00, sq_root_reg[ROOT_W]}) - sq_hb_reg[ROOT_W];
    assign mag_n = sum_n[SUM_W-1] ? HB_W'(-sum_n) : sum_n[HB_W-1:0];
    assign mag_f = dif_f[SUM_W-1] ? HB_W'(-dif_f) : dif_f[HB_W-1:0];

    logic [NUM_W-1:0] pn_num_reg, pf_num_reg;
    logic [SQ_W-1:0]  p_den_reg;

    // side data for the divider span, index 0 is the numerator stage
    logic          dv_v_reg    [0:NUM_W];
    logic          dv_ok_reg   [0:NUM_W];
    logic          dv_nneg_reg [0:NUM_W];
    logic          dv_fneg_reg [0:NUM_W];
    rsi_pkg::win_t dv_win_reg  [0:NUM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= sq_v_reg[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pn_num_reg     <= {mag_n, {F{1'b0}}};
            pf_num_reg     <= {mag_f, {F{1'b0}}};
            p_den_reg      <= sq_a_reg[ROOT_W];
            dv_ok_reg[0]   <= sq_ok_reg[ROOT_W];
            dv_nneg_reg[0] <= !sum_n[SUM_W-1] && (sum_n != '0);
            dv_fneg_reg[0] <= dif_f[SUM_W-1];
            dv_win_reg[0]  <= sq_win_reg[ROOT_W];
        end
    end

    logic [NUM_W-1:0] quo_n, quo_f;

    rsi_div_pipe u_div_near (
        .aclk (aclk),
        .en   (en),
        .num  (pn_num_reg),
        .den  (p_den_reg),
        .quo  (quo_n)
    );

    rsi_div_pipe u_div_far (
        .aclk (aclk),
        .en   (en),
        .num  (pf_num_reg),
        .den  (p_den_reg),
        .quo  (quo_f)
    );

    generate
        for (k = 0; k < NUM_W; k++) begin : g_side
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_v_reg[k+1] <= 1'b0;
                end else if (en) begin
                    dv_v_reg[k+1] <= dv_v_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_ok_reg[k+1]   <= dv_ok_reg[k];
                    dv_nneg_reg[k+1] <= dv_nneg_reg[k];
                    dv_fneg_reg[k+1] <= dv_fneg_reg[k];
                    dv_win_reg[k+1]  <= dv_win_reg[k];
                end
            end
        end
    endgenerate

    // ---------------- sign restore ----------------
    logic signed [T_W-1:0] tn_next, tf_next;

    assign tn_next = dv_nneg_reg[NUM_W] ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
    assign tf_next = dv_fneg_reg[NUM_W] ? -$signed({1'b0, quo_f}) : $signed({1'b0, quo_f});

    logic                  q_v_reg;
    logic                  q_ok_reg;
    logic signed [T_W-1:0] tn_reg, tf_reg;
    rsi_pkg::win_t         q_win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_v_reg <= 1'b0;
        end else if (en) begin
            q_v_reg <= dv_v_reg[NUM_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_ok_reg  <= dv_ok_reg[NUM_W];
            tn_reg    <= tn_next;
            tf_reg    <= tf_next;
            q_win_reg <= dv_win_reg[NUM_W];
        end
    end

    // ---------------- window test and output register ----------------
    logic signed [T_W-1:0] lo_ext, hi_ext;
    logic                  near_in, far_in;

    assign lo_ext  = T_W'(q_win_reg.t_min);
    assign hi_ext  = T_W'(q_win_reg.t_max);
    assign near_in = (tn_reg >= lo_ext) && (tn_reg <= hi_ext);
    assign far_in  = (tf_reg >= lo_ext) && (tf_reg <= hi_ext);

    logic                m_hit_reg, m_far_reg;
    logic signed [W-1:0] m_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q_v_reg;
        end
    end

    // an accepted t lies in the 32-bit window, so its low bits are exact
    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= q_ok_reg && (near_in || far_in);
            m_far_reg <= q_ok_reg && !near_in && far_in;
            if (q_ok_reg && near_in) begin
                m_t_reg <= tn_reg[W-1:0];
            end else if (q_ok_reg && far_in) begin
                m_t_reg <= tf_reg[W-1:0];
            end else begin
                m_t_reg <= '0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_t_hit    = m_t_reg;
    assign m_far_root = m_far_reg;

endmodule

// ===== rtl/rsi_checker.sv =====
// -----------------------------------------------------------------------------
// Ray-sphere intersection: port checker
// Watches the top-level ports and checks result coding and flow control.
// -----------------------------------------------------------------------------
`include "ray_sphere_intersection_macros.svh"

module rsi_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_origin_x,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_origin_y,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_origin_z,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_dir_x,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_dir_y,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_dir_z,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_center_x,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_center_y,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_center_z,
    input logic        [rsi_pkg::WORD_BITS-2:0] s_radius,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_t_min,
    input logic signed [rsi_pkg::WORD_BITS-1:0] s_t_max,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_hit,
    input logic signed [rsi_pkg::WORD_BITS-1:0] m_t_hit,
    input logic                                 m_far_root
);

    // a miss carries no distance and no root choice
    `RSI_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_valid && !m_hit,
        (m_t_hit == '0) && !m_far_root, "miss item with nonzero t_hit or far_root")

    `RSI_ASSERT_NOW(a_far_needs_hit, aclk, aresetn, m_valid && m_far_root,
        m_hit, "far_root set without hit")

    // pipe only stalls on a waiting result
    `RSI_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid || m_ready,
        s_ready, "input stalled with no result waiting")

    `RSI_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_hit) && $stable(m_t_hit) && $stable(m_far_root),
        "result changed while stalled")

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (.*);
